FILE: sv/can_sensor_frame_decoder_core_assert.svh
// ============================================================================
// CAN sensor frame decoder assertion macros
// Shared property forms for the decoder's concurrent checks.
// ============================================================================
`ifndef CAN_SENSOR_FRAME_DECODER_CORE_ASSERT_SVH
`define CAN_SENSOR_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CSFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CSFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/csfd_pkg.sv
// ============================================================================
// csfd_pkg
// Codes, constants and the decode record shared by the frame decoder files.
// ============================================================================
package csfd_pkg;

    // Default number of batteries and of IMUs
    localparam int DEVICE_COUNT_DEF = 16;

    localparam int VAL_W  = 21;
    localparam int FLAG_W = 11;
    localparam int MARK_W = 4;

    // Frame classes
    localparam logic [1:0] CLS_IGNORE  = 2'd0;
    localparam logic [1:0] CLS_BATTERY = 2'd1;
    localparam logic [1:0] CLS_IMU     = 2'd2;
    localparam logic [1:0] CLS_MOTOR   = 2'd3;

    // Record kinds
    localparam logic [3:0] KIND_NONE   = 4'd0;
    localparam logic [3:0] KIND_BSTATE = 4'd1;
    localparam logic [3:0] KIND_BTEMP  = 4'd2;
    localparam logic [3:0] KIND_BERROR = 4'd3;
    localparam logic [3:0] KIND_BCMDS  = 4'd4;
    localparam logic [3:0] KIND_ACCEL  = 4'd5;
    localparam logic [3:0] KIND_GYRO   = 4'd6;
    localparam logic [3:0] KIND_EULER  = 4'd7;
    localparam logic [3:0] KIND_QUAT   = 4'd8;

    // Battery id bases, in match order: state, temperature, error, commands
    localparam logic [3:0][10:0] BAT_BASE = {11'h1F4, 11'h0F4, 11'h2F4, 11'h3F4};
    localparam logic [3:0][3:0]  BAT_KIND = {KIND_BCMDS, KIND_BERROR, KIND_BTEMP,
                                             KIND_BSTATE};

    // IMU addressing: id[7:0] minus this base; type is id[28:8]
    localparam logic [7:0]  IMU_ADDR_BASE  = 8'h59;
    localparam logic [20:0] IMU_TYPE_ACCEL = 21'h0CF02D;
    localparam logic [20:0] IMU_TYPE_GYRO  = 21'h0CF02A;
    localparam logic [20:0] IMU_TYPE_EULER = 21'h0CF029;
    localparam logic [20:0] IMU_TYPE_QUAT  = 21'h0CF030;

    // Raw offsets
    localparam logic [VAL_W-1:0] OFS_ACC_EUL = 21'd32000;
    localparam logic [VAL_W-1:0] OFS_GYRO    = 21'd512000;
    localparam logic [VAL_W-1:0] OFS_QUAT    = 21'd32768;

    // One decoded frame, before the valid marks are merged in
    typedef struct packed {
        logic [1:0]        cls;
        logic [7:0]        idx;
        logic [3:0]        kind;
        logic [VAL_W-1:0]  val_a;
        logic [VAL_W-1:0]  val_b;
        logic [VAL_W-1:0]  val_c;
        logic [VAL_W-1:0]  val_d;
        logic [VAL_W-1:0]  val_e;
        logic [FLAG_W-1:0] flags;
        logic [MARK_W-1:0] mark;   // one-hot mark to set, zero if no update
    } decode_t;

    // Unsigned 16-bit field minus an offset, as a 21-bit two's complement value
    function automatic logic [VAL_W-1:0] sub16(input logic [15:0] h,
                                               input logic [VAL_W-1:0] ofs);
        return VAL_W'(h) - ofs;
    endfunction

    // 16-bit two's complement field sign extended
    function automatic logic [VAL_W-1:0] sext16(input logic [15:0] h);
        return {{(VAL_W-16){h[15]}}, h};
    endfunction

endpackage

FILE: sv/csfd_ram.sv
// ============================================================================
// csfd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module csfd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/csfd_decode.sv
// ============================================================================
// csfd_decode
// Classifies one CAN frame and unpacks its payload into raw fixed-point fields.
// ============================================================================
module csfd_decode
    import csfd_pkg::*;
#(
    parameter int DEVICE_COUNT = DEVICE_COUNT_DEF
) (
    input  logic [28:0] frame_id,
    input  logic        is_extended,
    input  logic [3:0]  byte_count,
    input  logic [63:0] payload,
    output decode_t     dec
);

    logic        len_ok;
    logic [15:0] h0, h1, h2, h3;
    logic [7:0]  b0, b1;
    logic [8:0]  imu_off;
    logic        imu_hit;
    logic [28:0] boff [4];
    logic [3:0]  bhit;
    logic [1:0]  bsel;
    logic        bany;
    logic        rec_ok;

    assign len_ok = (byte_count != 4'd0) && (byte_count <= 4'd8);
    assign h0 = payload[15:0];
    assign h1 = payload[31:16];
    assign h2 = payload[47:32];
    assign h3 = payload[63:48];
    assign b0 = payload[7:0];
    assign b1 = payload[15:8];

    // IMU address window
    assign imu_off = {1'b0, frame_id[7:0]} - {1'b0, IMU_ADDR_BASE};
    assign imu_hit = !imu_off[8] && (imu_off < 9'(DEVICE_COUNT));

    // Battery id windows; a low id wraps to a huge offset and misses
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            boff[k] = frame_id - 29'(BAT_BASE[k]);
            bhit[k] = boff[k] < 29'(DEVICE_COUNT);
        end
    end

    // First matching base wins
    always_comb
    begin
        bany = 1'b1;
        bsel = 2'd0;
        priority if (bhit[0]) bsel = 2'd0;
        else if (bhit[1])     bsel = 2'd1;
        else if (bhit[2])     bsel = 2'd2;
        else if (bhit[3])     bsel = 2'd3;
        else                  bany = 1'b0;
    end

    // Record decode
    always_comb
    begin
        dec    = '0;
        rec_ok = 1'b0;
        if (len_ok)
        begin
            if (is_extended)
            begin
                if (imu_hit)
                begin
                    unique case (frame_id[28:8])
                        IMU_TYPE_ACCEL:
                        begin
                            if (byte_count >= 4'd6)
                            begin
                                dec.kind  = KIND_ACCEL;
                                dec.val_a = sub16(h0, OFS_ACC_EUL);
                                dec.val_b = sub16(h1, OFS_ACC_EUL);
                                dec.val_c = sub16(h2, OFS_ACC_EUL);
                            end
                        end
                        IMU_TYPE_GYRO:
                        begin
                            if (byte_count == 4'd8)
                            begin
                                dec.kind  = KIND_GYRO;
                                dec.val_a = VAL_W'(payload[19:0]) - OFS_GYRO;
                                dec.val_b = VAL_W'(payload[39:20]) - OFS_GYRO;
                                dec.val_c = VAL_W'(payload[59:40]) - OFS_GYRO;
                            end
                        end
                        IMU_TYPE_EULER:
                        begin
                            if (byte_count >= 4'd6)
                            begin
                                dec.kind  = KIND_EULER;
                                dec.val_a = sub16(h0, OFS_ACC_EUL);
                                dec.val_b = sub16(h1, OFS_ACC_EUL);
                                dec.val_c = sub16(h2, OFS_ACC_EUL);
                            end
                        end
                        IMU_TYPE_QUAT:
                        begin
                            if (byte_count == 4'd8)
                            begin
                                dec.kind  = KIND_QUAT;
                                dec.val_a = sub16(h0, OFS_QUAT);
                                dec.val_b = sub16(h1, OFS_QUAT);
                                dec.val_c = sub16(h2, OFS_QUAT);
                                dec.val_d = sub16(h3, OFS_QUAT);
                            end
                        end
                        default:
                        begin
                            dec.kind = KIND_NONE;
                        end
                    endcase
                    if (dec.kind != KIND_NONE)
                    begin
                        dec.cls  = CLS_IMU;
                        dec.idx  = imu_off[7:0];
                        dec.mark = MARK_W'(1) << (dec.kind - KIND_ACCEL);
                    end
                end
            end
            else if (!bany)
            begin
                dec.cls = CLS_MOTOR;
            end
            else
            begin
                unique case (bsel)
                    2'd0:
                    begin
                        if (byte_count == 4'd8)
                        begin
                            rec_ok    = 1'b1;
                            dec.val_a = VAL_W'(b0 != 8'd0);
                            dec.val_b = VAL_W'(b1);
                            dec.val_c = VAL_W'(h1);
                            dec.val_d = VAL_W'(h2);
                            dec.val_e = VAL_W'(h3);
                        end
                    end
                    2'd1:
                    begin
                        if (byte_count == 4'd8)
                        begin
                            rec_ok    = 1'b1;
                            dec.val_a = sext16(h0);
                            dec.val_b = sext16(h1);
                            dec.val_c = VAL_W'(h2);
                            dec.val_d = VAL_W'(h3);
                        end
                    end
                    2'd2:
                    begin
                        if (byte_count >= 4'd2)
                        begin
                            rec_ok    = 1'b1;
                            dec.flags = {b1[2:0], b0};
                        end
                    end
                    2'd3:
                    begin
                        rec_ok    = 1'b1;
                        dec.flags = FLAG_W'(b0[5:0]);
                    end
                    default:
                    begin
                        rec_ok = 1'b0;
                    end
                endcase
                if (rec_ok)
                begin
                    dec.cls  = CLS_BATTERY;
                    dec.idx  = boff[bsel][7:0];
                    dec.kind = BAT_KIND[bsel];
                    dec.mark = MARK_W'(1) << bsel;
                end
            end
        end
    end

endmodule

FILE: sv/can_sensor_frame_decoder_core.sv
// ============================================================================
// can_sensor_frame_decoder_core
// Decodes CAN battery/IMU/motor frames into raw fixed-point records and keeps
// per-device record marks in a small RAM.
// ============================================================================
//
//  Channel  Dir  Handshake           Contents
//  s_*      in   s_tvalid/s_tready   frame: id, length, payload; tuser = extended
//  m_*      out  m_tvalid/m_tready   record: index, values, flags, marks;
//                                    tuser = class, kind
//
//  One item per cycle sustained while the output is not stalled; results pass
//  the middle stage and then the output register. Marks live in one RAM
//  (batteries, then IMUs), read on accept and written back when the item
//  leaves the middle stage; a write to the entry being read is forwarded.
//  After reset the mark RAM is cleared one entry per cycle, all 2 * DEVICE_COUNT
//  entries, with s_tready held low. A stalled output holds the middle stage;
//  input is taken while the output register drains.
//
`include "can_sensor_frame_decoder_core_assert.svh"

module can_sensor_frame_decoder_core
    import csfd_pkg::*;
#(
    parameter int DEVICE_COUNT = DEVICE_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // frame_id[28:0], byte_count[32:29],
                                    // payload[96:33], zero[103:97]
    input  logic         s_tuser,   // is_extended
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // device_index[7:0], value_a[28:8],
                                    // value_b[49:29], value_c[70:50],
                                    // value_d[91:71], value_e[112:92],
                                    // flag_bits[123:113], valid_mask[127:124]
    output logic [5:0]   m_tuser    // frame_class[1:0], record_kind[5:2]
);

    localparam int MEM_DEPTH = 2 * DEVICE_COUNT;
    localparam int AW        = $clog2(MEM_DEPTH);

    decode_t             dec;
    logic [AW-1:0]       dev_addr;
    logic                s_accept;
    logic                out_free;
    logic                retire;
    logic                ram_we;
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [MARK_W-1:0]   ram_wr_data;
    logic [MARK_W-1:0]   rd_data;
    logic [MARK_W-1:0]   old_mask;
    logic [MARK_W-1:0]   new_mask;
    logic                fwd_next;

    logic                s1_valid_reg;
    decode_t             s1_dec_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic                fwd_reg;
    logic [MARK_W-1:0]   fwd_data_reg;
    logic                clr_busy_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic                m_tvalid_reg;
    logic [127:0]        out_data_reg;
    logic [5:0]          out_user_reg;

    // Frame decode
    csfd_decode #(
        .DEVICE_COUNT (DEVICE_COUNT)
    ) u_decode (
        .frame_id    (s_tdata[28:0]),
        .is_extended (s_tuser),
        .byte_count  (s_tdata[32:29]),
        .payload     (s_tdata[96:33]),
        .dec         (dec)
    );

    // Mark RAM address: batteries first, IMUs after
    assign dev_addr = AW'(dec.idx) + ((dec.cls == CLS_IMU) ? AW'(DEVICE_COUNT) : '0);

    // Handshake
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !clr_busy_reg && (!s1_valid_reg || out_free);
    assign s_accept = s_tvalid && s_tready;
    assign retire   = s1_valid_reg && out_free;
    assign ram_we   = retire && (|s1_dec_reg.mark);

    // Write port: clearing pass after reset, then mark write-back
    assign ram_wr_en   = clr_busy_reg || ram_we;
    assign ram_wr_addr = clr_busy_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wr_data = clr_busy_reg ? {MARK_W{1'b0}} : new_mask;

    csfd_ram #(
        .WIDTH (MARK_W),
        .DEPTH (MEM_DEPTH)
    ) u_mark_ram (
        .clk     (clk),
        .we      (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (s_accept),
        .rd_addr (dev_addr),
        .rd_data (rd_data)
    );

    // Read-modify-write of the marks
    always_comb
    begin
        if (fwd_reg)
            old_mask = fwd_data_reg;
        else
            old_mask = rd_data;
        new_mask = old_mask | s1_dec_reg.mark;
    end

    assign fwd_next = ram_we && (s1_addr_reg == dev_addr);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MEM_DEPTH - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= fwd_next;
            end
            else if (retire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (retire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_dec_reg   <= dec;
            s1_addr_reg  <= dev_addr;
            fwd_data_reg <= new_mask;
        end
        if (retire)
        begin
            out_data_reg <= {(|s1_dec_reg.mark) ? new_mask : {MARK_W{1'b0}},
                             s1_dec_reg.flags,
                             s1_dec_reg.val_e, s1_dec_reg.val_d, s1_dec_reg.val_c,
                             s1_dec_reg.val_b, s1_dec_reg.val_a,
                             s1_dec_reg.idx};
            out_user_reg <= {s1_dec_reg.kind, s1_dec_reg.cls};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Checks
    `CSFD_ASSERT_IMP(a_marked_has_mask,
        m_tvalid_reg && (out_user_reg[1:0] == CLS_BATTERY || out_user_reg[1:0] == CLS_IMU),
        out_data_reg[127:124] != 4'd0, "device record without a mark")
    `CSFD_ASSERT_IMP(a_other_clean,
        m_tvalid_reg && (out_user_reg[1:0] == CLS_IGNORE || out_user_reg[1:0] == CLS_MOTOR),
        out_data_reg[127:124] == 4'd0 && out_user_reg[5:2] == KIND_NONE,
        "ignore or motor record carries kind or marks")
    `CSFD_ASSERT_NXT(a_stall_hold, s1_valid_reg && !out_free,
        s1_valid_reg && $stable(s1_addr_reg), "middle stage lost during stall")
    `CSFD_ASSERT_IMP(a_fwd_source, fwd_reg && s1_valid_reg && $rose(s1_valid_reg),
        $past(ram_we), "forward flag without a write")
    `CSFD_ASSERT_IMP(a_clear_blocks_input, clr_busy_reg,
        !s_tready && !s1_valid_reg, "input taken while the mark RAM is cleared")

endmodule
